// ===== hdl/akrt_pkg.sv =====
// shared types, constants and codes for the analog key rapid trigger block
package akrt_pkg;

    // key table size
    localparam int KEY_COUNT = 64;
    localparam int KEY_W     = 6;
    localparam int POS_W     = 8;

    // decoupling queue between classifier and state update
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_ACT_LEVEL        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_POINT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_MODE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_DISTANCE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_DISTANCE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_TYPE      = 3'd5;

    // trigger modes
    localparam logic [1:0] MODE_STATIC     = 2'd0;
    localparam logic [1:0] MODE_RAPID      = 2'd1;
    localparam logic [1:0] MODE_RAPID_ZERO = 2'd2;

    // key direction codes
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;

    // hysteresis margins and the automatic release point code
    localparam logic [POS_W-1:0] MARGIN_TYPE0  = 8'd8;
    localparam logic [POS_W-1:0] MARGIN_TYPE1  = 8'd7;
    localparam logic [POS_W-1:0] RELEASE_AUTO  = 8'd255;

    // register reset values
    localparam logic [POS_W-1:0] RST_ACT_LEVEL        = 8'd128;
    localparam logic [POS_W-1:0] RST_RELEASE_POINT    = 8'd255;
    localparam logic [1:0]       RST_TRIGGER_MODE     = MODE_STATIC;
    localparam logic [POS_W-1:0] RST_PRESS_DISTANCE   = 8'd16;
    localparam logic [POS_W-1:0] RST_RELEASE_DISTANCE = 8'd0;
    localparam logic             RST_SWITCH_TYPE      = 1'b0;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic [POS_W-1:0] position;
    } sample_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_id;
        logic             pressed;
        logic             state_changed;
        logic [1:0]       direction;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0] act_level;
        logic [POS_W-1:0] release_point;
        logic [1:0]       trigger_mode;
        logic [POS_W-1:0] press_distance;
        logic [POS_W-1:0] release_distance;
        logic             switch_type;
    } cfg_t;

    // classified sample waiting in the queue
    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic [POS_W-1:0] position;
        logic             above_act;
        logic             at_release;
    } item_t;

    // per-key stored state
    typedef struct packed {
        logic [1:0]       direction;
        logic             pressed;
        logic [POS_W-1:0] turning;
    } key_rec_t;

endpackage

// ===== hdl/akrt_ram.sv =====
// generic single write port, single read port ram with registered read
module akrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/akrt_front.sv =====
// front end: classifies a sample against the actuation and release thresholds
module akrt_front (
    input  akrt_pkg::cfg_t    cfg,
    input  akrt_pkg::sample_t sample,
    output akrt_pkg::item_t   item
);

    logic [akrt_pkg::POS_W-1:0] margin;
    logic [akrt_pkg::POS_W-1:0] lowered;
    logic [akrt_pkg::POS_W-1:0] release_pos;

    always_comb
    begin
        margin  = cfg.switch_type ? akrt_pkg::MARGIN_TYPE1 : akrt_pkg::MARGIN_TYPE0;
        // actuation minus margin, saturating at zero
        lowered = (cfg.act_level > margin) ? (cfg.act_level - margin) : '0;

        if (cfg.trigger_mode == akrt_pkg::MODE_STATIC)
        begin
            release_pos = (cfg.release_point == akrt_pkg::RELEASE_AUTO) ? lowered
                                                                        : cfg.release_point;
        end
        else if (cfg.trigger_mode == akrt_pkg::MODE_RAPID_ZERO)
        begin
            release_pos = '0;
        end
        else
        begin
            release_pos = lowered;
        end

        item.key_index  = sample.key_index;
        item.position   = sample.position;
        item.above_act  = sample.position > cfg.act_level;
        item.at_release = sample.position <= release_pos;
    end

endmodule

// ===== hdl/akrt_queue.sv =====
// short fifo between the classifier and the key state update
module akrt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  akrt_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output akrt_pkg::item_t head_item
);

    localparam int PTR_W = (akrt_pkg::QUEUE_DEPTH > 1) ? $clog2(akrt_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(akrt_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(akrt_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(akrt_pkg::QUEUE_DEPTH);

    akrt_pkg::item_t  entry_reg [akrt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/akrt_back.sv =====
// back end: key state lookup, trigger update, write back and result register
module akrt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  akrt_pkg::cfg_t   cfg,
    input  logic             head_valid,
    input  akrt_pkg::item_t  head_item,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output akrt_pkg::result_t result
);

    // lookup stage
    logic                         stage_valid_reg;
    akrt_pkg::item_t              stage_item_reg;
    logic                         stage_fwd_reg;
    logic                         stage_hit_reg;
    akrt_pkg::key_rec_t           fwd_state_reg;
    logic [akrt_pkg::KEY_COUNT-1:0] entry_valid_reg;

    // result register
    logic                         out_valid_reg;
    akrt_pkg::result_t            out_reg;

    logic                         out_free;
    logic                         stage_fire;
    akrt_pkg::key_rec_t           ram_state;
    akrt_pkg::key_rec_t           cur_state;
    akrt_pkg::key_rec_t           new_state;
    akrt_pkg::result_t            new_result;
    logic [akrt_pkg::POS_W-1:0]   rel_dist;
    logic [akrt_pkg::POS_W-1:0]   pos;
    logic [akrt_pkg::POS_W-1:0]   prev;

    assign out_free   = !out_valid_reg || !result_stall;
    assign stage_fire = stage_valid_reg && out_free;
    assign pop        = head_valid && (!stage_valid_reg || stage_fire);

    akrt_ram #(
        .WIDTH ($bits(akrt_pkg::key_rec_t)),
        .DEPTH (akrt_pkg::KEY_COUNT)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (stage_fire),
        .wr_addr (stage_item_reg.key_index),
        .wr_data (new_state),
        .rd_en   (pop),
        .rd_addr (head_item.key_index),
        .rd_data (ram_state)
    );

    always_comb
    begin
        // forwarded write beats ram, unwritten key reads as reset state
        if (stage_fwd_reg)
        begin
            cur_state = fwd_state_reg;
        end
        else if (stage_hit_reg)
        begin
            cur_state = ram_state;
        end
        else
        begin
            cur_state = '0;
        end

        rel_dist  = (cfg.release_distance == '0) ? cfg.press_distance : cfg.release_distance;
        pos       = stage_item_reg.position;
        prev      = cur_state.turning;
        new_state = cur_state;

        if (cfg.trigger_mode == akrt_pkg::MODE_STATIC)
        begin
            new_state.direction = akrt_pkg::DIR_IDLE;
            if (stage_item_reg.above_act)
            begin
                new_state.pressed = 1'b1;
            end
            else if (stage_item_reg.at_release)
            begin
                new_state.pressed = 1'b0;
            end
        end
        else if (cur_state.direction == akrt_pkg::DIR_IDLE)
        begin
            if (stage_item_reg.above_act)
            begin
                new_state.turning   = pos;
                new_state.direction = akrt_pkg::DIR_DOWN;
                new_state.pressed   = 1'b1;
            end
        end
        else if (stage_item_reg.at_release)
        begin
            new_state.turning   = pos;
            new_state.direction = akrt_pkg::DIR_IDLE;
            new_state.pressed   = 1'b0;
        end
        else if (cur_state.direction == akrt_pkg::DIR_DOWN)
        begin
            if (pos > prev)
            begin
                new_state.turning = pos;
            end
            else if ((prev > pos) && ((prev - pos) > rel_dist))
            begin
                new_state.turning   = pos;
                new_state.direction = akrt_pkg::DIR_UP;
                new_state.pressed   = 1'b0;
            end
        end
        else
        begin
            if (pos < prev)
            begin
                new_state.turning = pos;
            end
            else if ((pos > prev) && ((pos - prev) > cfg.press_distance))
            begin
                new_state.turning   = pos;
                new_state.direction = akrt_pkg::DIR_DOWN;
                new_state.pressed   = 1'b1;
            end
        end

        new_result.key_id        = stage_item_reg.key_index;
        new_result.pressed       = new_state.pressed;
        new_result.state_changed = new_state.pressed != cur_state.pressed;
        new_result.direction     = new_state.direction;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            stage_fwd_reg   <= 1'b0;
            stage_hit_reg   <= 1'b0;
            entry_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                stage_valid_reg <= 1'b1;
                stage_fwd_reg   <= stage_fire &&
                                   (stage_item_reg.key_index == head_item.key_index);
                stage_hit_reg   <= entry_valid_reg[head_item.key_index];
            end
            else if (stage_fire)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (stage_fire)
            begin
                entry_valid_reg[stage_item_reg.key_index] <= 1'b1;
            end
            if (out_free)
            begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            stage_item_reg <= head_item;
        end
        if (stage_fire)
        begin
            fwd_state_reg <= new_state;
            out_reg       <= new_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== hdl/analog_key_rapid_trigger.sv =====
// top level of the analog key rapid trigger block
// path: a sample passes the queue, the lookup stage and the result register in turn
// throughput: one sample per cycle while result_stall is low; the state ram has one
//   read and one write port and a same-key sample right behind another is forwarded
// reset: configuration returns to its defaults and the per-key valid bits clear,
//   so every key reads as inactive, released, turning position zero
// the key state ram itself is not cleared; no clearing pass, samples accepted at once
module analog_key_rapid_trigger (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample channel
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  akrt_pkg::sample_t                 sample,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output akrt_pkg::result_t                 result,
    // configuration write port
    input  logic                              cfg_write_en,
    input  logic [akrt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [akrt_pkg::CFG_DATA_W-1:0]   cfg_data
);

    akrt_pkg::cfg_t  cfg_reg;
    akrt_pkg::item_t front_item;
    akrt_pkg::item_t head_item;
    logic            queue_full;
    logic            queue_push;
    logic            head_valid;
    logic            queue_pop;

    // configuration registers; writes to unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.act_level        <= akrt_pkg::RST_ACT_LEVEL;
            cfg_reg.release_point    <= akrt_pkg::RST_RELEASE_POINT;
            cfg_reg.trigger_mode     <= akrt_pkg::RST_TRIGGER_MODE;
            cfg_reg.press_distance   <= akrt_pkg::RST_PRESS_DISTANCE;
            cfg_reg.release_distance <= akrt_pkg::RST_RELEASE_DISTANCE;
            cfg_reg.switch_type      <= akrt_pkg::RST_SWITCH_TYPE;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                akrt_pkg::REG_ACT_LEVEL:        cfg_reg.act_level        <= cfg_data;
                akrt_pkg::REG_RELEASE_POINT:    cfg_reg.release_point    <= cfg_data;
                akrt_pkg::REG_TRIGGER_MODE:     cfg_reg.trigger_mode     <= cfg_data[1:0];
                akrt_pkg::REG_PRESS_DISTANCE:   cfg_reg.press_distance   <= cfg_data;
                akrt_pkg::REG_RELEASE_DISTANCE: cfg_reg.release_distance <= cfg_data;
                akrt_pkg::REG_SWITCH_TYPE:      cfg_reg.switch_type      <= cfg_data[0];
                default:                        ;
            endcase
        end
    end

    // front: threshold compares need no key state, so they happen at transfer
    akrt_front u_front (
        .cfg    (cfg_reg),
        .sample (sample),
        .item   (front_item)
    );

    // a sample is taken whenever the queue has room
    assign sample_stall = queue_full;
    assign queue_push   = sample_valid && !queue_full;

    akrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .push_item  (front_item),
        .full       (queue_full),
        .pop        (queue_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // back: read-modify-write of the key state and the result register
    akrt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (queue_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // a key moving down is always pressed
    a_down_pressed : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.direction == akrt_pkg::DIR_DOWN) |-> result.pressed)
        else $error("key moving down reported as released");

    // a key moving up after a release is never pressed
    a_up_released : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.direction == akrt_pkg::DIR_UP) |-> !result.pressed)
        else $error("key moving up reported as pressed");

    // static threshold mode never reports a direction
    a_static_idle : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (cfg_reg.trigger_mode == akrt_pkg::MODE_STATIC)
        |-> (result.direction == akrt_pkg::DIR_IDLE))
        else $error("direction reported in static threshold mode");

    // nothing leaves the queue that was not put in
    a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        queue_pop |-> head_valid)
        else $error("queue popped while empty");

endmodule
